>>> rtl/frdef_pkg.sv
// ----------------------------------------------------------------------------
// Frame deframer package
// Shared widths, register indexes, reset values, result kind codes and types for the deframer.
// ----------------------------------------------------------------------------
`default_nettype none

package frdef_pkg;

   localparam int BYTE_W  = 8;
   localparam int LEN_W   = 16;
   localparam int KIND_W  = 2;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;

   // Configuration register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_SYNC_FIRST  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SYNC_SECOND = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_PAYLOAD = 2'd2;

   // Configuration reset values.
   localparam logic [BYTE_W-1:0] SYNC_FIRST_RST  = 8'd181;
   localparam logic [BYTE_W-1:0] SYNC_SECOND_RST = 8'd98;
   localparam logic [LEN_W-1:0]  MAX_PAYLOAD_RST = 16'd1024;

   // Result kind codes.
   localparam logic [KIND_W-1:0] KIND_DATA   = 2'd0;
   localparam logic [KIND_W-1:0] KIND_CK_OK  = 2'd1;
   localparam logic [KIND_W-1:0] KIND_CK_BAD = 2'd2;

   typedef logic [BYTE_W-1:0] byte_type;
   typedef logic [LEN_W-1:0]  len_type;
   typedef logic [KIND_W-1:0] kind_type;

endpackage

`default_nettype wire

>>> rtl/frdef_req_if.sv
// ----------------------------------------------------------------------------
// Deframer request channel
// Valid/ready channel that carries one received byte per request.
// ----------------------------------------------------------------------------
`default_nettype none

interface frdef_req_if;
   import frdef_pkg::*;

   logic     valid;
   logic     ready;
   byte_type rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink   (input valid, input rx_byte, output ready);
endinterface

`default_nettype wire

>>> rtl/frdef_rsp_if.sv
// ----------------------------------------------------------------------------
// Deframer result channel
// Valid/ready channel that carries payload bytes and frame status results.
// ----------------------------------------------------------------------------
`default_nettype none

interface frdef_rsp_if;
   import frdef_pkg::*;

   logic     valid;
   logic     ready;
   kind_type kind;
   byte_type class_code;
   byte_type msg_id;
   len_type  payload_len;
   len_type  byte_index;
   byte_type data_byte;

   modport source (output valid, output kind, output class_code, output msg_id,
                   output payload_len, output byte_index, output data_byte,
                   input ready);
   modport sink   (input valid, input kind, input class_code, input msg_id,
                   input payload_len, input byte_index, input data_byte,
                   output ready);
endinterface

`default_nettype wire

>>> rtl/ubx_frame_deframer.sv
// ----------------------------------------------------------------------------
// Sync-prefixed frame deframer with 8-bit Fletcher checksum
// Parses a byte stream into frames, forwards payload bytes and reports
// the checksum outcome of every frame.
// ----------------------------------------------------------------------------
// Usage:
//   req_if carries one received byte per request. rsp_if carries zero or one
//   result per request: a payload byte with its offset, or a final status
//   (checksum good or bad) after the second checksum byte of a frame.
//   Sync bytes, header bytes, the first checksum byte and frames whose length
//   exceeds max_payload produce no result.
//   The csr_ port writes sync_first, sync_second and max_payload; it should
//   only be written while no frame is in progress.
// Throughput and output timing:
//   One request per cycle unless a held result stalls rsp_if. A result
//   appears on rsp_if in the cycle after the request that caused it is
//   accepted. The parser state and the output register are the only
//   storage, so the byte rate is set by the single parse step between them.
// Reset:
//   Synchronous, active high. The parser hunts for the first sync byte, the
//   output register is empty and the configuration returns to its defaults.
// Stalls:
//   While a result is held because rsp_if.ready is low, req_if.ready is low.
//   When the result is taken in a cycle, a new request is accepted in the
//   same cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module ubx_frame_deframer (
   input  wire logic                            clock,
   input  wire logic                            reset,
   frdef_req_if.sink                            req_if,
   frdef_rsp_if.source                          rsp_if,
   input  wire logic                            csr_we,
   input  wire logic [frdef_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [frdef_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import frdef_pkg::*;

   typedef enum logic [3:0] {
      ST_SYNC1,
      ST_SYNC2,
      ST_CLASS,
      ST_ID,
      ST_LEN_LO,
      ST_LEN_HI,
      ST_PAYLOAD,
      ST_CK_A,
      ST_CK_B
   } state_type;

   // Configuration registers.
   byte_type sync_first_ff;
   byte_type sync_second_ff;
   len_type  max_payload_ff;

   // Parser state.
   state_type state_ff, state_in;
   byte_type  cur_class_ff, cur_class_in;
   byte_type  cur_id_ff, cur_id_in;
   byte_type  len_low_ff, len_low_in;
   len_type   cur_len_ff, cur_len_in;
   len_type   idx_ff, idx_in;
   byte_type  sum_a_ff, sum_a_in;
   byte_type  sum_b_ff, sum_b_in;
   byte_type  ck_low_ff, ck_low_in;

   // Output register.
   logic     out_valid_ff;
   logic     emit;
   kind_type kind_ff, kind_in;
   len_type  out_idx_ff, out_idx_in;
   byte_type out_data_ff, out_data_in;
   byte_type out_class_ff;
   byte_type out_id_ff;
   len_type  out_len_ff;

   logic     accept;
   byte_type b;
   byte_type fold_a;
   byte_type fold_b;
   len_type  new_len;

   // A new request is taken whenever the output register is empty or is
   // being drained in this cycle.
   assign req_if.ready = !out_valid_ff || rsp_if.ready;
   assign accept       = req_if.valid && req_if.ready;
   assign b            = req_if.rx_byte;

   // Running Fletcher sums after folding in the current byte.
   assign fold_a  = sum_a_ff + b;
   assign fold_b  = sum_b_ff + fold_a;
   assign new_len = {b, len_low_ff};

   always_comb begin
      state_in     = state_ff;
      cur_class_in = cur_class_ff;
      cur_id_in    = cur_id_ff;
      len_low_in   = len_low_ff;
      cur_len_in   = cur_len_ff;
      idx_in       = idx_ff;
      sum_a_in     = sum_a_ff;
      sum_b_in     = sum_b_ff;
      ck_low_in    = ck_low_ff;
      emit         = 1'b0;
      kind_in      = KIND_DATA;
      out_idx_in   = idx_ff;
      out_data_in  = b;

      case (state_ff)
         ST_SYNC1: begin
            state_in = (b == sync_first_ff) ? ST_SYNC2 : ST_SYNC1;
         end
         ST_SYNC2: begin
            // A mismatch is not retried as a first sync byte.
            state_in = (b == sync_second_ff) ? ST_CLASS : ST_SYNC1;
         end
         ST_CLASS: begin
            cur_class_in = b;
            sum_a_in     = b;
            sum_b_in     = b;
            state_in     = ST_ID;
         end
         ST_ID: begin
            cur_id_in = b;
            sum_a_in  = fold_a;
            sum_b_in  = fold_b;
            state_in  = ST_LEN_LO;
         end
         ST_LEN_LO: begin
            len_low_in = b;
            sum_a_in   = fold_a;
            sum_b_in   = fold_b;
            state_in   = ST_LEN_HI;
         end
         ST_LEN_HI: begin
            cur_len_in = new_len;
            sum_a_in   = fold_a;
            sum_b_in   = fold_b;
            idx_in     = '0;
            if (new_len > max_payload_ff) begin
               state_in = ST_SYNC1;
            end else if (new_len == '0) begin
               state_in = ST_CK_A;
            end else begin
               state_in = ST_PAYLOAD;
            end
         end
         ST_PAYLOAD: begin
            sum_a_in = fold_a;
            sum_b_in = fold_b;
            idx_in   = idx_ff + 16'd1;
            emit     = 1'b1;
            if (idx_ff == cur_len_ff - 16'd1) begin
               state_in = ST_CK_A;
            end
         end
         ST_CK_A: begin
            ck_low_in = b;
            state_in  = ST_CK_B;
         end
         ST_CK_B: begin
            emit        = 1'b1;
            out_idx_in  = cur_len_ff;
            out_data_in = '0;
            kind_in     = (ck_low_ff == sum_a_ff && b == sum_b_ff) ?
                          KIND_CK_OK : KIND_CK_BAD;
            state_in    = ST_SYNC1;
         end
         default: begin
            state_in = ST_SYNC1;
         end
      endcase
   end

   // Configuration writes; an unused index is ignored.
   always_ff @(posedge clock) begin
      if (reset) begin
         sync_first_ff  <= SYNC_FIRST_RST;
         sync_second_ff <= SYNC_SECOND_RST;
         max_payload_ff <= MAX_PAYLOAD_RST;
      end else if (csr_we) begin
         case (csr_index)
            CSR_SYNC_FIRST:  sync_first_ff  <= csr_wdata[BYTE_W-1:0];
            CSR_SYNC_SECOND: sync_second_ff <= csr_wdata[BYTE_W-1:0];
            CSR_MAX_PAYLOAD: max_payload_ff <= csr_wdata[LEN_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // Parser state and output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_SYNC1;
         out_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            state_ff <= state_in;
         end
         if (accept) begin
            out_valid_ff <= emit;
         end else if (rsp_if.ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         cur_class_ff <= cur_class_in;
         cur_id_ff    <= cur_id_in;
         len_low_ff   <= len_low_in;
         cur_len_ff   <= cur_len_in;
         idx_ff       <= idx_in;
         sum_a_ff     <= sum_a_in;
         sum_b_ff     <= sum_b_in;
         ck_low_ff    <= ck_low_in;
         if (emit) begin
            kind_ff      <= kind_in;
            out_idx_ff   <= out_idx_in;
            out_data_ff  <= out_data_in;
            out_class_ff <= cur_class_ff;
            out_id_ff    <= cur_id_ff;
            out_len_ff   <= cur_len_ff;
         end
      end
   end

   assign rsp_if.valid       = out_valid_ff;
   assign rsp_if.kind        = kind_ff;
   assign rsp_if.class_code  = out_class_ff;
   assign rsp_if.msg_id      = out_id_ff;
   assign rsp_if.payload_len = out_len_ff;
   assign rsp_if.byte_index  = out_idx_ff;
   assign rsp_if.data_byte   = out_data_ff;

endmodule

`default_nettype wire

>>> verif/tb_ubx_frame_deframer.sv
// ----------------------------------------------------------------------------
// Frame deframer testbench
// Feeds byte streams of sync-prefixed frames, noise, broken syncs, oversize
// lengths and cut-off frames through the deframer under several register
// settings, and compares every payload byte and frame status it reports
// with a cycle-free parser model kept in a small scoreboard class.
// ----------------------------------------------------------------------------
import frdef_pkg::*;

typedef struct packed {
   kind_type kind;
   byte_type class_code;
   byte_type msg_id;
   len_type  payload_len;
   len_type  byte_index;
   byte_type data_byte;
} frame_result_type;

class deframe_checker;
   localparam logic [16:0] POS_SYNC1   = 17'd0;
   localparam logic [16:0] POS_SYNC2   = 17'd1;
   localparam logic [16:0] POS_CLASS   = 17'd2;
   localparam logic [16:0] POS_ID      = 17'd3;
   localparam logic [16:0] POS_LEN_LO  = 17'd4;
   localparam logic [16:0] POS_LEN_HI  = 17'd5;
   localparam logic [16:0] POS_PAYLOAD = 17'd6;

   byte_type sync_first_reg;
   byte_type sync_second_reg;
   len_type  max_len_reg;

   logic [16:0] position;
   byte_type    frame_class;
   byte_type    frame_id;
   byte_type    len_low;
   len_type     frame_len;
   byte_type    sum_a;
   byte_type    sum_b;
   byte_type    check_low;

   frame_result_type pending_results[$];
   int unsigned   failures;
   int unsigned   requests;
   int unsigned   payload_results;
   int unsigned   good_frames;
   int unsigned   bad_frames;

   function new();
      sync_first_reg  = SYNC_FIRST_RST;
      sync_second_reg = SYNC_SECOND_RST;
      max_len_reg     = MAX_PAYLOAD_RST;
      position    = POS_SYNC1;
      frame_class = '0;
      frame_id    = '0;
      len_low     = '0;
      frame_len   = '0;
      sum_a       = '0;
      sum_b       = '0;
      check_low   = '0;
   endfunction

   function void set_register(logic [CSR_IDX_W-1:0] index, logic [CSR_DATA_W-1:0] value);
      case (index)
         CSR_SYNC_FIRST:  sync_first_reg  = value[BYTE_W-1:0];
         CSR_SYNC_SECOND: sync_second_reg = value[BYTE_W-1:0];
         CSR_MAX_PAYLOAD: max_len_reg     = value[LEN_W-1:0];
         default: ;
      endcase
   endfunction

   function bit hunting();
      return position == POS_SYNC1;
   endfunction

   function void fold(byte_type value);
      sum_a = sum_a + value;
      sum_b = sum_b + sum_a;
   endfunction

   function void push_result(kind_type kind, len_type index, byte_type value);
      frame_result_type r;
      r.kind        = kind;
      r.class_code  = frame_class;
      r.msg_id      = frame_id;
      r.payload_len = frame_len;
      r.byte_index  = index;
      r.data_byte   = value;
      pending_results.push_back(r);
   endfunction

   // Advances the parser by one accepted byte and queues what it reports.
   function void parse_byte(byte_type value);
      logic [16:0] frame_end;
      logic [16:0] offset;
      frame_end = {1'b0, frame_len} + POS_PAYLOAD;
      requests++;
      if (position == POS_SYNC1) begin
         position = (value == sync_first_reg) ? POS_SYNC2 : POS_SYNC1;
      end else if (position == POS_SYNC2) begin
         // A wrong second sync byte is dropped, not retried as a first one.
         position = (value == sync_second_reg) ? POS_CLASS : POS_SYNC1;
      end else if (position == POS_CLASS) begin
         frame_class = value;
         sum_a = '0;
         sum_b = '0;
         fold(value);
         position = POS_ID;
      end else if (position == POS_ID) begin
         frame_id = value;
         fold(value);
         position = POS_LEN_LO;
      end else if (position == POS_LEN_LO) begin
         len_low = value;
         fold(value);
         position = POS_LEN_HI;
      end else if (position == POS_LEN_HI) begin
         frame_len = {value, len_low};
         fold(value);
         position = (frame_len > max_len_reg) ? POS_SYNC1 : POS_PAYLOAD;
      end else if (position < frame_end) begin
         offset = position - POS_PAYLOAD;
         fold(value);
         position = position + 17'd1;
         push_result(KIND_DATA, offset[LEN_W-1:0], value);
      end else if (position == frame_end) begin
         check_low = value;
         position  = position + 17'd1;
      end else begin
         position = POS_SYNC1;
         if (check_low == sum_a && value == sum_b) begin
            push_result(KIND_CK_OK, frame_len, '0);
         end else begin
            push_result(KIND_CK_BAD, frame_len, '0);
         end
      end
   endfunction

   function string describe(frame_result_type r);
      return $sformatf("kind=%0d class=%02h id=%02h len=%0d index=%0d data=%02h",
                       r.kind, r.class_code, r.msg_id, r.payload_len, r.byte_index,
                       r.data_byte);
   endfunction

   function void check_result(frame_result_type got);
      frame_result_type want;
      string         wrong;
      if (pending_results.size() == 0) begin
         failures++;
         if (failures <= 10) $display("ERROR: unexpected result %s", describe(got));
         return;
      end
      want = pending_results.pop_front();
      case (want.kind)
         KIND_DATA:  payload_results++;
         KIND_CK_OK: good_frames++;
         default:    bad_frames++;
      endcase
      wrong = "";
      if (got.kind !== want.kind)               wrong = {wrong, " kind"};
      if (got.class_code !== want.class_code)   wrong = {wrong, " class_code"};
      if (got.msg_id !== want.msg_id)           wrong = {wrong, " msg_id"};
      if (got.payload_len !== want.payload_len) wrong = {wrong, " payload_len"};
      if (got.byte_index !== want.byte_index)   wrong = {wrong, " byte_index"};
      if (got.data_byte !== want.data_byte)     wrong = {wrong, " data_byte"};
      if (wrong != "") begin
         failures++;
         if (failures <= 10) begin
            $display("ERROR: mismatch in%s", wrong);
            $display("   expected %s", describe(want));
            $display("   actual   %s", describe(got));
         end
      end
   endfunction
endclass

module tb_ubx_frame_deframer;
   timeunit 1ns;
   timeprecision 1ps;

   // Index 3 is not a register; writes to it must leave everything alone.
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED = 2'd3;
   localparam int unsigned ITEMS_PER_PHASE = 240;
   // Longest quiet stretch of a correct run is the forced receiver hold-off
   // plus a few fully stalled receiver patterns; this is several times that.
   localparam int unsigned STUCK_LIMIT = 4000;
   localparam int unsigned HOLD_CYCLES = 300;

   logic clock = 1'b0;
   logic reset;
   logic csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   frdef_req_if req_ch ();
   frdef_rsp_if rsp_ch ();

   ubx_frame_deframer i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_if    (req_ch),
      .rsp_if    (rsp_ch),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   deframe_checker chk;
   byte_type       tx_bytes[$];
   int unsigned    burst_left = 0;
   int unsigned    settings_used = 0;
   int unsigned    stuck_cycles = 0;
   int unsigned    hold_left = 0;
   int unsigned    mode_left = 0;
   int unsigned    stall_mode = 0;
   logic [7:0]     stall_bits = 8'h00;
   bit             hold_arm = 1'b0;
   int unsigned    leftover;

   // 50 MHz clock.
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // The receiver picks a stall style for a random stretch of cycles: always
   // ready, mostly ready, mostly stalled, or a rotating bit pattern. When the
   // stimulus arms a hold-off, it refuses results for a long stretch so that
   // the output register fills and the deframer has to push back on its input.
   always @(negedge clock) begin
      if (hold_arm) begin
         hold_arm  = 1'b0;
         hold_left = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
         hold_left--;
         rsp_ch.ready <= 1'b0;
      end else begin
         if (mode_left == 0) begin
            stall_mode = $urandom_range(0, 3);
            mode_left  = $urandom_range(16, 96);
            stall_bits = 8'($urandom);
         end
         mode_left--;
         case (stall_mode)
            0: rsp_ch.ready <= 1'b1;
            1: rsp_ch.ready <= ($urandom_range(0, 3) != 0);
            2: rsp_ch.ready <= ($urandom_range(0, 3) == 0);
            default: begin
               rsp_ch.ready <= stall_bits[0];
               stall_bits = {stall_bits[0], stall_bits[7:1]};
            end
         endcase
      end
   end

   // Every result taken by the receiver is checked against the oldest one
   // the model predicted.
   always @(posedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         chk.check_result('{rsp_ch.kind, rsp_ch.class_code, rsp_ch.msg_id,
                            rsp_ch.payload_len, rsp_ch.byte_index, rsp_ch.data_byte});
      end
   end

   // Watchdog: the run is declared hung if neither channel moves for too long.
   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         stuck_cycles = 0;
      end else begin
         stuck_cycles++;
      end
      if (stuck_cycles == STUCK_LIMIT) begin
         $display("ERROR: timeout, no request or result moved for %0d cycles", STUCK_LIMIT);
         $display("CHECKS FAILED");
         $finish;
      end
   end

   // Offers one byte and returns after it has been accepted. The sender works
   // in bursts; valid stays high from one byte to the next inside a burst and
   // drops for a random gap between bursts. Every task here starts and ends
   // just after a falling edge.
   task automatic send_byte(input byte_type value);
      if (burst_left == 0) begin
         req_ch.valid = 1'b0;
         repeat ($urandom_range(1, 6)) @(negedge clock);
         burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 250)
                                                  : $urandom_range(1, 30);
      end
      req_ch.valid   = 1'b1;
      req_ch.rx_byte = value;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      chk.parse_byte(value);
      burst_left--;
      @(negedge clock);
   endtask

   task automatic send_queued();
      while (tx_bytes.size() != 0) send_byte(tx_bytes.pop_front());
   endtask

   // Stops offering bytes and waits until every predicted result has come
   // back, then lets the one-stage output register settle.
   task automatic settle();
      req_ch.valid = 1'b0;
      burst_left   = 0;
      while (chk.pending_results.size() != 0) @(negedge clock);
      repeat (3) @(negedge clock);
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] index,
                            input logic [CSR_DATA_W-1:0] value);
      csr_we    = 1'b1;
      csr_index = index;
      csr_wdata = value;
      @(negedge clock);
      csr_we = 1'b0;
      chk.set_register(index, value);
   endtask

   // Queues a complete frame whose checksum is computed here, optionally
   // spoiled in one of its two bytes.
   function automatic void append_frame(input byte_type s1, s2, cls, id,
                                        input byte_type body[$], input bit corrupt);
      byte_type covered[$];
      byte_type run_a;
      byte_type run_b;
      len_type  n;
      n = 16'(body.size());
      covered = {cls, id, n[7:0], n[15:8]};
      covered = {covered, body};
      run_a = '0;
      run_b = '0;
      foreach (covered[i]) begin
         run_a = run_a + covered[i];
         run_b = run_b + run_a;
      end
      if (corrupt) begin
         if ($urandom_range(0, 1) == 1) run_a ^= 8'($urandom_range(1, 255));
         else                           run_b ^= 8'($urandom_range(1, 255));
      end
      tx_bytes = {tx_bytes, s1, s2, covered, run_a, run_b};
   endfunction

   // Hand-picked cases under the reset register values.
   task automatic run_directed();
      byte_type body[$];
      settings_used++;
      // Shortest frame: the checksum follows the length bytes directly.
      append_frame(SYNC_FIRST_RST, SYNC_SECOND_RST, 8'h00, 8'hFF, body, 1'b0);
      // Extreme payload values in a frame whose checksum is wrong.
      body = {8'h00, 8'hFF};
      append_frame(SYNC_FIRST_RST, SYNC_SECOND_RST, 8'hFF, 8'h00, body, 1'b1);
      // A repeated first sync byte fails the second sync check and is not
      // taken as a new first sync byte, so the second sync byte is ignored.
      tx_bytes = {tx_bytes, SYNC_FIRST_RST, SYNC_FIRST_RST, SYNC_SECOND_RST};
      // Start a frame and stop before its length.
      tx_bytes = {tx_bytes, SYNC_FIRST_RST, SYNC_SECOND_RST, 8'h07, 8'h08};
      send_queued();
      settle();
      // Registers written in the middle of a frame: the new maximum length
      // applies to this frame, the new sync byte only to the next hunt, and
      // the write to the spare index is ignored.
      write_csr(CSR_MAX_PAYLOAD, 16'h0000);
      write_csr(CSR_SYNC_FIRST, 16'hA511);
      write_csr(CSR_UNUSED, 16'hFFFF);
      settings_used++;
      // Length 1 now exceeds the maximum of 0, so the frame is dropped.
      tx_bytes = {8'h01, 8'h00};
      send_queued();
      settle();
   endtask

   // One register setting followed by random traffic. Most of it is
   // well-formed frames with random content; the rest is noise, a bad
   // second sync byte, an oversize length, a bad checksum or a frame cut off
   // inside its payload or checksum.
   task automatic run_phase(input byte_type s1, s2, input len_type max_len,
                            input bit with_hold);
      int unsigned start_count;
      int unsigned pick;
      int unsigned n;
      int unsigned cap;
      byte_type    body[$];
      bit          armed;
      write_csr(CSR_SYNC_FIRST, {8'($urandom), s1});
      write_csr(CSR_SYNC_SECOND, {8'($urandom), s2});
      write_csr(CSR_MAX_PAYLOAD, max_len);
      settings_used++;
      start_count = chk.requests;
      armed = 1'b0;
      while (chk.requests - start_count < ITEMS_PER_PHASE) begin
         if (with_hold && !armed && chk.requests - start_count > ITEMS_PER_PHASE / 3) begin
            hold_arm = 1'b1;
            armed    = 1'b1;
         end
         pick = $urandom_range(0, 99);
         body.delete();
         if (pick < 10) begin
            repeat ($urandom_range(1, 6)) tx_bytes.push_back(8'($urandom));
         end else if (pick < 16) begin
            tx_bytes.push_back(s1);
            do n = $urandom_range(0, 255); while (n == s2);
            tx_bytes.push_back(8'(n));
         end else if (pick < 22 && max_len != 16'hFFFF) begin
            n = ($urandom_range(0, 1) == 1) ? max_len + 1 : $urandom_range(max_len + 1, 65535);
            tx_bytes = {tx_bytes, s1, s2, 8'($urandom), 8'($urandom), n[7:0], n[15:8]};
         end else begin
            // Mostly short payloads; now and then the maximum or, for a large maximum, one of up to 300 bytes.
            cap = (max_len < 16) ? max_len : 16;
            n = $urandom_range(0, cap);
            if ($urandom_range(0, 15) == 0) n = (max_len <= 300) ? max_len : $urandom_range(0, 300);
            repeat (n) body.push_back(8'($urandom));
            append_frame(s1, s2, 8'($urandom), 8'($urandom), body, pick < 30);
            // Cut-off frames lose bytes from the tail only, so the header
            // stays whole and the following bytes are read as its remainder.
            if (pick >= 96) repeat ($urandom_range(1, n + 2)) void'(tx_bytes.pop_back());
         end
         send_queued();
      end
      // Bring the parser back to hunting so the next register writes land
      // between frames.
      while (!chk.hunting()) send_byte(8'($urandom));
      settle();
   endtask

   initial begin
      chk = new();
      reset          = 1'b1;
      req_ch.valid   = 1'b0;
      req_ch.rx_byte = '0;
      rsp_ch.ready   = 1'b0;
      csr_we         = 1'b0;
      csr_index      = '0;
      csr_wdata      = '0;
      repeat (5) @(negedge clock);
      reset = 1'b0;

      run_directed();
      run_phase(8'h00, 8'hFF, 16'h0000, 1'b0);
      run_phase(8'hFF, 8'h00, 16'hFFFF, 1'b1);
      run_phase(8'($urandom), 8'($urandom), 16'($urandom_range(1, 400)), 1'b0);
      run_phase(8'h5A, 8'h5A, 16'd7, 1'b0);
      run_phase(SYNC_FIRST_RST, SYNC_SECOND_RST, MAX_PAYLOAD_RST, 1'b0);

      leftover = chk.pending_results.size();
      $display("Run covered %0d received bytes under %0d register settings.",
               chk.requests, settings_used);
      $display("Checked %0d payload bytes, %0d good frames and %0d bad-checksum frames.",
               chk.payload_results, chk.good_frames, chk.bad_frames);
      if (chk.failures == 0 && leftover == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("%0d mismatches, %0d results never arrived", chk.failures, leftover);
         $display("CHECKS FAILED");
      end
      $finish;
   end
endmodule
